// File: rtl/lbs_pkg.sv
// ----------------------------------------------------------------------------
// lbs_pkg
// Shared constants and types for the linear blend skinning pipeline.
// ----------------------------------------------------------------------------
package lbs_pkg;

    localparam int BONE_COUNT_DEF = 64;
    localparam int INFLUENCES_DEF = 4;
    localparam int CARRIED_INFL   = 4;   // influences that have bits in the item
    localparam int ELEMS          = 12;
    localparam int IDX_W          = 6;
    localparam int ELEM_W         = 4;
    localparam int VAL_W          = 32;
    localparam int WGT_W          = 16;
    localparam int PROD_W         = 48;  // Q32.16 product: the Q32.32 product after floor >> 16
    localparam int XFORM_W        = 50;  // transformed coordinate
    localparam int WEIGHED_W      = 52;  // coordinate * weight >> 15
    localparam int ACC_W          = 54;

    // Input tdata layout, lowest bit up
    localparam int IN_DATA_W = 232;
    localparam int OFS_BONE  = 0;
    localparam int OFS_ELEM  = 6;
    localparam int OFS_VAL   = 10;
    localparam int OFS_PX    = 42;
    localparam int OFS_PY    = 74;
    localparam int OFS_PZ    = 106;
    localparam int OFS_IDX   = 138;
    localparam int OFS_WGT   = 162;
    localparam int OUT_DATA_W = 96;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_SKIN = 1'b1;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  bone;
        logic [ELEM_W-1:0] elem;
        logic [VAL_W-1:0]  value;
    } t_load;

endpackage

// File: rtl/lbs_ram.sv
// ----------------------------------------------------------------------------
// lbs_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic                                 i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/lbs_lane.sv
// ----------------------------------------------------------------------------
// lbs_lane
// One influence: private copy of the bone matrices, transform, weighting.
// ----------------------------------------------------------------------------
module lbs_lane #(
    parameter int BONE_COUNT = lbs_pkg::BONE_COUNT_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_ce,
    input  lbs_pkg::t_load                         i_load,
    input  logic [lbs_pkg::IDX_W-1:0]              i_bone,
    input  logic [lbs_pkg::WGT_W-1:0]              i_weight,
    input  logic signed [lbs_pkg::VAL_W-1:0]       i_pos [3],
    output logic signed [lbs_pkg::WEIGHED_W-1:0]   o_weighed [3]
);

    localparam int AW = BONE_COUNT > 1 ? $clog2(BONE_COUNT) : 1;

    logic [lbs_pkg::VAL_W-1:0] m [lbs_pkg::ELEMS];
    logic                      wr_ok;
    logic                      rd_ok;

    assign wr_ok = i_load.we && (int'(i_load.bone) < BONE_COUNT)
                   && (int'(i_load.elem) < lbs_pkg::ELEMS);
    assign rd_ok = int'(i_bone) < BONE_COUNT;

    for (genvar e = 0; e < lbs_pkg::ELEMS; e++) begin : g_elem
        lbs_ram #(.WIDTH(lbs_pkg::VAL_W), .DEPTH(BONE_COUNT)) u_ram (
            .i_clk   (i_clk),
            .i_we    (wr_ok && (int'(i_load.elem) == e)),
            .i_waddr (AW'(i_load.bone)),
            .i_wdata (i_load.value),
            .i_re    (i_ce),
            .i_raddr (AW'(i_bone)),
            .o_rdata (m[e])
        );
    end

    // stage 1 (alongside RAM read data)
    logic                             r_inr;
    logic [lbs_pkg::WGT_W-1:0]        r_w1;
    logic signed [lbs_pkg::VAL_W-1:0] r_p [3];
    // stage 2
    logic signed [lbs_pkg::PROD_W-1:0] r_prod [3][3];
    logic signed [lbs_pkg::VAL_W-1:0]  r_tr [3];
    logic [lbs_pkg::WGT_W-1:0]         r_w2;
    // stage 3
    logic signed [lbs_pkg::XFORM_W-1:0] r_t [3];
    logic [lbs_pkg::WGT_W-1:0]          r_w3;
    // stage 4
    logic signed [lbs_pkg::WEIGHED_W-1:0] r_o [3];

    logic signed [lbs_pkg::PROD_W-1:0]    n_prod [3][3];
    logic signed [lbs_pkg::VAL_W-1:0]     n_tr [3];
    logic signed [lbs_pkg::XFORM_W-1:0]   n_t [3];
    logic signed [lbs_pkg::WEIGHED_W-1:0] n_o [3];

    always_comb begin
        logic signed [2*lbs_pkg::VAL_W-1:0]               prod;
        logic signed [lbs_pkg::XFORM_W+lbs_pkg::WGT_W:0]  wp;
        for (int c = 0; c < 3; c++) begin
            n_tr[c] = r_inr ? $signed(m[9+c]) : '0;
            for (int k = 0; k < 3; k++) begin
                prod = r_p[k] * $signed(m[3*k+c]);
                n_prod[k][c] = r_inr ? prod[2*lbs_pkg::VAL_W-1:16] : '0;
            end
            n_t[c] = lbs_pkg::XFORM_W'(r_tr[c]) + lbs_pkg::XFORM_W'(r_prod[0][c])
                   + lbs_pkg::XFORM_W'(r_prod[1][c]) + lbs_pkg::XFORM_W'(r_prod[2][c]);
            wp = r_t[c] * $signed({1'b0, r_w3});
            n_o[c] = wp[lbs_pkg::XFORM_W+lbs_pkg::WGT_W:15];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_inr <= rd_ok;
            r_w1  <= i_weight;
            r_p   <= i_pos;
            r_prod <= n_prod;
            r_tr  <= n_tr;
            r_w2  <= r_w1;
            r_t   <= n_t;
            r_w3  <= r_w2;
            r_o   <= n_o;
        end
    end

    assign o_weighed = r_o;

endmodule

// File: rtl/linear_blend_vertex_skinning.sv
// ----------------------------------------------------------------------------
// linear_blend_vertex_skinning
// Linear blend skinning of Q16.16 vertex positions, up to four influences.
// ----------------------------------------------------------------------------
// Stages from input transfer to result: matrix read, multiply, transform sum,
// weight multiply, blend and clamp, each ending in a register.
// Throughput: one item per cycle; the whole pipeline stalls only when the
// output register is full and not taken.
// Reset clears the valid bits and holds the input not ready; matrices are
// undefined until loaded.
// ----------------------------------------------------------------------------
module linear_blend_vertex_skinning #(
    parameter int BONE_COUNT = lbs_pkg::BONE_COUNT_DEF,
    parameter int INFLUENCES = lbs_pkg::INFLUENCES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // load_bone, load_element, load_value, pos_x, pos_y, pos_z,
    // bone_indices, blend_weights
    input  logic [lbs_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    input  logic                              s_axis_tuser,   // mode
    input  logic                              s_axis_tlast,   // end_of_batch
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [lbs_pkg::OUT_DATA_W-1:0]    m_axis_tdata,   // out_x, out_y, out_z
    output logic                              m_axis_tuser,   // saturated
    output logic                              m_axis_tlast    // batch_end
);

    localparam int LANES = INFLUENCES < lbs_pkg::CARRIED_INFL ? INFLUENCES
                                                              : lbs_pkg::CARRIED_INFL;
    localparam int PIPE  = 4;

    logic                              ce;
    logic                              acc_in;
    lbs_pkg::t_load                    load;
    logic signed [lbs_pkg::VAL_W-1:0]  pos [3];
    logic signed [lbs_pkg::WEIGHED_W-1:0] lane_o [LANES][3];

    logic [PIPE-1:0] r_v;
    logic [PIPE-1:0] r_last;
    logic            r_ov;
    logic            r_olast;
    logic            r_osat;
    logic [lbs_pkg::OUT_DATA_W-1:0] r_odata;

    logic [lbs_pkg::OUT_DATA_W-1:0] n_odata;
    logic                           n_osat;

    assign ce            = !r_ov || m_axis_tready;
    assign s_axis_tready = ce && i_rst_n;
    assign acc_in        = s_axis_tvalid && s_axis_tready;

    assign load.we    = acc_in && (s_axis_tuser == lbs_pkg::MODE_LOAD);
    assign load.bone  = s_axis_tdata[lbs_pkg::OFS_BONE +: lbs_pkg::IDX_W];
    assign load.elem  = s_axis_tdata[lbs_pkg::OFS_ELEM +: lbs_pkg::ELEM_W];
    assign load.value = s_axis_tdata[lbs_pkg::OFS_VAL  +: lbs_pkg::VAL_W];

    assign pos[0] = s_axis_tdata[lbs_pkg::OFS_PX +: lbs_pkg::VAL_W];
    assign pos[1] = s_axis_tdata[lbs_pkg::OFS_PY +: lbs_pkg::VAL_W];
    assign pos[2] = s_axis_tdata[lbs_pkg::OFS_PZ +: lbs_pkg::VAL_W];

    // influences past the carried four have no bits in the item and are left out
    for (genvar j = 0; j < LANES; j++) begin : g_lane
        lbs_lane #(.BONE_COUNT(BONE_COUNT)) u_lane (
            .i_clk      (i_clk),
            .i_ce       (ce),
            .i_load     (load),
            .i_bone     (s_axis_tdata[lbs_pkg::OFS_IDX + j*lbs_pkg::IDX_W +: lbs_pkg::IDX_W]),
            .i_weight   (s_axis_tdata[lbs_pkg::OFS_WGT + j*lbs_pkg::WGT_W +: lbs_pkg::WGT_W]),
            .i_pos      (pos),
            .o_weighed  (lane_o[j])
        );
    end

    always_comb begin
        logic signed [lbs_pkg::ACC_W-1:0] s;
        n_osat = 1'b0;
        for (int c = 0; c < 3; c++) begin
            s = '0;
            for (int j = 0; j < LANES; j++) begin
                s = s + lbs_pkg::ACC_W'(lane_o[j][c]);
            end
            if (s > lbs_pkg::ACC_W'(64'sh7FFF_FFFF)) begin
                n_odata[32*c +: 32] = 32'h7FFF_FFFF;
                n_osat = 1'b1;
            end else if (s < -(lbs_pkg::ACC_W'(64'sh8000_0000))) begin
                n_odata[32*c +: 32] = 32'h8000_0000;
                n_osat = 1'b1;
            end else begin
                n_odata[32*c +: 32] = s[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_ov <= 1'b0;
        end else if (ce) begin
            r_v  <= {r_v[PIPE-2:0], acc_in && (s_axis_tuser == lbs_pkg::MODE_SKIN)};
            r_ov <= r_v[PIPE-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_last  <= {r_last[PIPE-2:0], s_axis_tlast};
            r_olast <= r_last[PIPE-1];
            r_osat  <= n_osat;
            r_odata <= n_odata;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_osat;
    assign m_axis_tlast  = r_olast;

endmodule
